/* sv/sawbc_pkg.sv */
// Package with shared types and codes for the set-associative write-back cache.
package sawbc_pkg;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    localparam logic [2:0] RK_READ   = 3'd0;
    localparam logic [2:0] RK_WDONE  = 3'd1;
    localparam logic [2:0] RK_WBACK  = 3'd2;
    localparam logic [2:0] RK_FETCH  = 3'd3;
    localparam logic [2:0] RK_REJECT = 3'd4;

    localparam logic [15:0] LFSR_SEED = 16'h0001;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_SERVE = 6'b000100,
        ST_WBACK = 6'b001000,
        ST_FILL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

/* sv/set_assoc_writeback_cache.sv */
// Top level of the set-associative write-back, write-allocate cache.
//
//  Channel  | Handshake            | Fields
//  ---------+----------------------+------------------------------------------------
//  request  | start / busy         | kind, addr, wdata, wmask, fill_index, fill_data
//  result   | rvalid (one cycle)   | rkind, rdata, hit, block_number, word_index,
//           |                      | word_data, last
//
// A hit passes through tag read, data read and modify-write (ST_SERVE) to its result.
// A miss ends in a fetch result, after a write-back when the victim is dirty (one data
// memory read per write-back word). The sixteenth fill word goes on to DONE and SERVE.
// Reset clears the valid and dirty bits held in flip-flops; the memories need no pass.
// The result receiver cannot stall; each result stands on the ports for one cycle.
module set_assoc_writeback_cache #(
    parameter int TOTAL_SIZE_LOG = 14,
    parameter int WAYS_LOG       = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [24:0] addr,
    input  logic [31:0] wdata,
    input  logic [31:0] wmask,
    input  logic [3:0]  fill_index,
    input  logic [31:0] fill_data,
    output logic        rvalid,
    output logic [2:0]  rkind,
    output logic [31:0] rdata,
    output logic        hit,
    output logic [18:0] block_number,
    output logic [3:0]  word_index,
    output logic [31:0] word_data,
    output logic        last
);

    localparam int LINE_BITS = TOTAL_SIZE_LOG - 6;
    localparam int NUM_LINES = 1 << LINE_BITS;
    localparam int SET_BITS  = (LINE_BITS >= WAYS_LOG) ? (LINE_BITS - WAYS_LOG) : 0;
    localparam int WAY_BITS  = LINE_BITS - SET_BITS;
    localparam int NUM_WAYS  = 1 << WAY_BITS;
    localparam int SB        = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WB        = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int TAG_BITS  = 19 - SET_BITS;
    localparam int SET_ROWS  = 1 << SET_BITS;
    localparam int DATA_BITS = LINE_BITS + 4;

    // Tag memory: one row per set, all ways side by side.
    logic [NUM_WAYS*TAG_BITS-1:0] tag_mem [SET_ROWS];
    logic [31:0]                  data_mem [1 << DATA_BITS];

    logic [NUM_LINES-1:0] valid_reg, valid_next;
    logic [NUM_LINES-1:0] dirty_reg, dirty_next;

    sawbc_pkg::state_t state_reg, state_next;
    logic [15:0] lfsr_reg, lfsr_next;
    logic        pend_reg, pend_next;
    logic        pwrite_reg, pwrite_next;
    logic [24:0] paddr_reg, paddr_next;
    logic [31:0] pwdata_reg, pwdata_next;
    logic [31:0] pwmask_reg, pwmask_next;
    logic [WB-1:0] way_reg, way_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        phit_reg, phit_next;
    logic [18:0] wbblk_reg, wbblk_next;

    logic [NUM_WAYS*TAG_BITS-1:0] tag_rd_reg;
    logic [31:0]                  data_rd_reg;

    // Memory ports
    logic                         tag_we;
    logic [SB-1:0]                tag_waddr, tag_raddr;
    logic [NUM_WAYS*TAG_BITS-1:0] tag_wdata;
    logic                         data_we;
    logic [DATA_BITS-1:0]         data_waddr, data_raddr;
    logic [31:0]                  data_wdata;

    // Result register
    logic        rvalid_reg, rvalid_next;
    logic [2:0]  rkind_reg, rkind_next;
    logic [31:0] rdata_reg, rdata_next;
    logic        hit_reg, hit_next;
    logic [18:0] blk_reg, blk_next;
    logic [3:0]  widx_reg, widx_next;
    logic [31:0] wdat_reg, wdat_next;
    logic        last_reg, last_next;

    logic [SB-1:0]       pset;
    logic [TAG_BITS-1:0] ptag;
    logic [WB-1:0]       hit_way;
    logic                any_hit;
    logic [LINE_BITS-1:0] pline, vline, mline;
    logic                lfsr_bit;
    logic [15:0]         lfsr_adv;

    assign pset = (SET_BITS > 0) ? SB'(paddr_reg[6 +: SB]) : '0;
    assign ptag = paddr_reg[24 -: TAG_BITS];

    always_comb
    begin
        hit_way = '0;
        any_hit = 1'b0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (valid_reg[LINE_BITS'(i) + (SET_BITS > 0 ? LINE_BITS'(pset) << WAY_BITS : '0)]
                && tag_rd_reg[i*TAG_BITS +: TAG_BITS] == ptag)
            begin
                hit_way = WB'(i);
                any_hit = 1'b1;
            end
        end
    end

    function automatic logic [LINE_BITS-1:0] line_of(input logic [SB-1:0] s,
                                                     input logic [WB-1:0] w);
        logic [LINE_BITS-1:0] l;
        l = '0;
        if (SET_BITS > 0)
            l = LINE_BITS'(s) << WAY_BITS;
        if (WAY_BITS > 0)
            l = l | LINE_BITS'(w);
        return l;
    endfunction

    assign lfsr_bit = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_adv = {lfsr_bit, lfsr_reg[15:1]};
    assign pline    = line_of(pset, hit_way);
    assign vline    = line_of(pset, way_reg);
    // Line that a miss in the lookup cycle evicts.
    assign mline    = line_of(pset, WB'(lfsr_adv));

    assign busy = (state_reg != sawbc_pkg::ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        lfsr_next   = lfsr_reg;
        pend_next   = pend_reg;
        pwrite_next = pwrite_reg;
        paddr_next  = paddr_reg;
        pwdata_next = pwdata_reg;
        pwmask_next = pwmask_reg;
        way_next    = way_reg;
        cnt_next    = cnt_reg;
        phit_next   = phit_reg;
        wbblk_next  = wbblk_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;

        tag_we     = 1'b0;
        tag_waddr  = pset;
        tag_raddr  = pset;
        tag_wdata  = tag_rd_reg;
        data_we    = 1'b0;
        data_waddr = {pline, paddr_reg[5:2]};
        data_raddr = {pline, paddr_reg[5:2]};
        data_wdata = (data_rd_reg & ~pwmask_reg) | (pwdata_reg & pwmask_reg);

        rvalid_next = 1'b0;
        rkind_next  = sawbc_pkg::RK_READ;
        rdata_next  = '0;
        hit_next    = 1'b0;
        blk_next    = '0;
        widx_next   = '0;
        wdat_next   = '0;
        last_next   = 1'b0;

        case (state_reg)
            sawbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == sawbc_pkg::KIND_FILL && pend_reg)
                    begin
                        data_we    = 1'b1;
                        data_waddr = {vline, fill_index};
                        data_wdata = fill_data;
                        cnt_next   = cnt_reg + 5'd1;
                        if (cnt_reg == 5'd15)
                        begin
                            valid_next[vline] = 1'b1;
                            dirty_next[vline] = 1'b0;
                            phit_next = 1'b0;
                            cnt_next  = '0;
                            pend_next = 1'b0;
                            state_next = sawbc_pkg::ST_DONE;
                        end
                    end
                    else if ((kind == sawbc_pkg::KIND_READ || kind == sawbc_pkg::KIND_WRITE)
                             && !pend_reg)
                    begin
                        pwrite_next = (kind == sawbc_pkg::KIND_WRITE);
                        paddr_next  = addr;
                        pwdata_next = wdata;
                        pwmask_next = wmask;
                        tag_raddr   = (SET_BITS > 0) ? SB'(addr[6 +: SB]) : '0;
                        state_next  = sawbc_pkg::ST_LOOK;
                    end
                    else
                    begin
                        rvalid_next = 1'b1;
                        rkind_next  = sawbc_pkg::RK_REJECT;
                        last_next   = 1'b1;
                    end
                end
            end
            sawbc_pkg::ST_LOOK:
            begin
                if (any_hit)
                begin
                    // Read the word; a write merges it in the next cycle.
                    way_next   = hit_way;
                    phit_next  = 1'b1;
                    state_next = sawbc_pkg::ST_SERVE;
                end
                else
                begin
                    lfsr_next = lfsr_adv;
                    way_next  = WB'(lfsr_adv);
                    if (WAY_BITS == 0)
                        way_next = '0;
                    wbblk_next = 19'(tag_rd_reg[32'(way_next)*TAG_BITS +: TAG_BITS])
                                 << SET_BITS | 19'(pset);
                    if (SET_BITS == 0)
                        wbblk_next = 19'(tag_rd_reg[32'(way_next)*TAG_BITS +: TAG_BITS]);
                    tag_we = 1'b1;
                    tag_wdata[32'(way_next)*TAG_BITS +: TAG_BITS] = ptag;
                    valid_next[mline] = 1'b0;
                    dirty_next[mline] = 1'b0;
                    pend_next  = 1'b1;
                    cnt_next   = '0;
                    data_raddr = {mline, 4'd0};
                    if (valid_reg[mline] && dirty_reg[mline])
                        state_next = sawbc_pkg::ST_WBACK;
                    else
                    begin
                        rvalid_next = 1'b1;
                        rkind_next  = sawbc_pkg::RK_FETCH;
                        blk_next    = paddr_reg[24:6];
                        last_next   = 1'b1;
                        state_next  = sawbc_pkg::ST_IDLE;
                    end
                end
            end
            sawbc_pkg::ST_WBACK:
            begin
                // Word cnt is in the read register; fetch the next one.
                data_raddr = {vline, cnt_reg[3:0] + 4'd1};
                rvalid_next = 1'b1;
                if (cnt_reg == 5'd16)
                begin
                    rkind_next = sawbc_pkg::RK_FETCH;
                    blk_next   = paddr_reg[24:6];
                    last_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = sawbc_pkg::ST_IDLE;
                end
                else
                begin
                    rkind_next = sawbc_pkg::RK_WBACK;
                    blk_next   = wbblk_reg;
                    widx_next  = cnt_reg[3:0];
                    wdat_next  = data_rd_reg;
                    cnt_next   = cnt_reg + 5'd1;
                end
            end
            sawbc_pkg::ST_DONE:
            begin
                // Issue the data read for the completed fill.
                data_raddr = {vline, paddr_reg[5:2]};
                way_next   = way_reg;
                state_next = sawbc_pkg::ST_SERVE;
            end
            sawbc_pkg::ST_SERVE:
            begin
                rvalid_next = 1'b1;
                hit_next    = phit_reg;
                last_next   = 1'b1;
                data_waddr  = {vline, paddr_reg[5:2]};
                if (pwrite_reg)
                begin
                    data_we    = 1'b1;
                    dirty_next[vline] = 1'b1;
                    rkind_next = sawbc_pkg::RK_WDONE;
                end
                else
                begin
                    rkind_next = sawbc_pkg::RK_READ;
                    rdata_next = data_rd_reg;
                end
                state_next = sawbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sawbc_pkg::ST_IDLE;
            end
        endcase

        // On a hit the serve read uses the hit way.
        if (state_reg == sawbc_pkg::ST_LOOK && any_hit)
            data_raddr = {pline, paddr_reg[5:2]};
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= tag_wdata;
        tag_rd_reg <= tag_mem[tag_raddr];
        if (data_we)
            data_mem[data_waddr] <= data_wdata;
        data_rd_reg <= data_mem[data_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sawbc_pkg::ST_IDLE;
            lfsr_reg   <= sawbc_pkg::LFSR_SEED;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
            valid_reg  <= '0;
            dirty_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lfsr_reg   <= lfsr_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pwrite_reg <= pwrite_next;
        paddr_reg  <= paddr_next;
        pwdata_reg <= pwdata_next;
        pwmask_reg <= pwmask_next;
        way_reg    <= way_next;
        phit_reg   <= phit_next;
        wbblk_reg  <= wbblk_next;
        rkind_reg  <= rkind_next;
        rdata_reg  <= rdata_next;
        hit_reg    <= hit_next;
        blk_reg    <= blk_next;
        widx_reg   <= widx_next;
        wdat_reg   <= wdat_next;
        last_reg   <= last_next;
    end

    assign rvalid       = rvalid_reg;
    assign rkind        = rkind_reg;
    assign rdata        = rdata_reg;
    assign hit          = hit_reg;
    assign block_number = blk_reg;
    assign word_index   = widx_reg;
    assign word_data    = wdat_reg;
    assign last         = last_reg;

    a_pend_no_serve: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sawbc_pkg::ST_SERVE |-> !pend_reg)
        else $error("access served while a miss is still pending");
    a_wback_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sawbc_pkg::ST_WBACK |-> cnt_reg <= 5'd16)
        else $error("write-back counter overran");
    a_hit_only_access: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && hit_reg |-> rkind_reg == sawbc_pkg::RK_READ
                                  || rkind_reg == sawbc_pkg::RK_WDONE)
        else $error("hit flag on a result that is not a completed access");
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 16'd0)
        else $error("victim LFSR reached the all-zero lockup state");

endmodule
